### hdl/mi3_pkg.sv
`default_nettype none

package mi3_pkg;

    localparam int DW            = 32;            // entry width
    localparam int FRAC_BITS_DEF = 16;            // default fraction bits
    localparam int NE            = 9;             // entries per matrix
    localparam int PW            = 2 * DW;        // 2x2 product
    localparam int CW            = 2 * DW + 1;    // cofactor
    localparam int DETW          = 3 * DW + 3;    // determinant
    localparam int DIV_STEPS     = DW;            // quotient bits below the saturation check

    typedef logic signed [DW-1:0]   t_entry;
    typedef logic signed [CW-1:0]   t_cof;
    typedef logic signed [DETW-1:0] t_det;

    typedef struct packed {
        logic signed [DW-1:0] a00;
        logic signed [DW-1:0] a01;
        logic signed [DW-1:0] a02;
        logic signed [DW-1:0] a10;
        logic signed [DW-1:0] a11;
        logic signed [DW-1:0] a12;
        logic signed [DW-1:0] a20;
        logic signed [DW-1:0] a21;
        logic signed [DW-1:0] a22;
    } t_matrix;

    typedef struct packed {
        logic signed [DW-1:0] inv00;
        logic signed [DW-1:0] inv01;
        logic signed [DW-1:0] inv02;
        logic signed [DW-1:0] inv10;
        logic signed [DW-1:0] inv11;
        logic signed [DW-1:0] inv12;
        logic signed [DW-1:0] inv20;
        logic signed [DW-1:0] inv21;
        logic signed [DW-1:0] inv22;
        logic                 singular;
        logic                 overflow;
    } t_inverse;

    // side data that rides along the divider
    typedef struct packed {
        logic [NE-1:0] neg;
        logic          singular;
    } t_side;

    // adjugate entry k = a[p]*a[q] - a[r]*a[s], entries in row-major order
    localparam int COF_IDX [0:NE-1][0:3] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

`default_nettype wire

### hdl/matrix_inverse_3x3.sv
`default_nettype none

// 3x3 matrix inverse, signed fixed point, adjugate over determinant
//
// input: a beat is taken on a rising edge with start high and busy low;
//   i_matrix carries all nine entries. busy never rises, so a new matrix
//   may be issued on every cycle
// output: o_done strobes for one cycle with the inverse on o_result; the
//   receiver cannot hold results off and none is needed, every beat
//   leaves the pipe in the order it was taken
// throughput: one matrix per cycle, set by the fully pipelined datapath:
//   4 stages of products, cofactors and determinant, 1 stage that forms
//   numerator and divisor, a saturation check and then restoring steps in
//   each of nine divider lanes, 1 stage of sign, saturation and flags
// entries are round(adj * 2^(2*FRAC_BITS) / det), ties away from zero,
//   saturated to the output range with overflow set; a zero determinant
//   gives zero entries, singular set and overflow clear
// reset: synchronous active-low reset clears the valid bits, so no strobe
//   comes out of beats that were in flight; there is no clearing pass
module matrix_inverse_3x3 #(
    parameter int FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire mi3_pkg::t_matrix  i_matrix,
    output logic                   o_done,
    output mi3_pkg::t_inverse      o_result
);
    import mi3_pkg::*;

    // numerator |c| * 2^(2F+1) + |d| and divisor shifted by the quotient width
    localparam int NUMW  = ((CW + 2 * FRAC_BITS + 1) > DETW) ? (CW + 2 * FRAC_BITS + 1) : DETW;
    localparam int DSHW  = DETW + 1 + DIV_STEPS;
    localparam int NW    = ((NUMW > DSHW) ? NUMW : DSHW) + 1;
    localparam int SHAMT = 2 * FRAC_BITS + 1;

    logic                 w_acc;
    logic                 w_adj_vld;
    t_cof                 w_cof   [NE];
    t_det                 w_det;
    logic [DETW-1:0]      w_ad;
    logic [NW-1:0]        r_num   [NE];
    logic [NW-1:0]        r_den;
    t_side                w_side;
    t_side                r_p_side;
    logic                 r_p_vld;
    t_side                r_sd    [DIV_STEPS+1];
    logic [DIV_STEPS:0]   r_sv;
    logic [DIV_STEPS-1:0] w_quo   [NE];
    logic                 w_big   [NE];
    t_entry               w_inv   [NE];
    logic [NE-1:0]        w_ovf;
    t_inverse             w_res;
    t_inverse             r_res;
    logic                 r_done;

    // every cycle is open for a new matrix
    assign busy  = 1'b0;
    assign w_acc = start && !busy;

    mi3_adj u_adj (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_acc),
        .i_matrix (i_matrix),
        .o_valid  (w_adj_vld),
        .o_cof    (w_cof),
        .o_det    (w_det)
    );

    // magnitude of the determinant and the per-entry result signs
    assign w_ad = w_det[DETW-1] ? ((~w_det) + DETW'(1)) : w_det;

    always_comb begin
        w_side.singular = (w_det == '0);
        for (int k = 0; k < NE; k++) begin
            w_side.neg[k] = w_cof[k][CW-1] ^ w_det[DETW-1];
        end
    end

    genvar k;
    generate
        for (k = 0; k < NE; k++) begin : g_lane
            logic [CW-1:0] w_ac;

            assign w_ac = w_cof[k][CW-1] ? ((~w_cof[k]) + CW'(1)) : w_cof[k];

            // adding |d| before dividing by 2|d| rounds half away from zero
            always_ff @(posedge i_clk) begin
                r_num[k] <= (NW'(w_ac) << SHAMT) + NW'(w_ad);
            end

            mi3_div #(
                .NW (NW),
                .QW (DIV_STEPS)
            ) u_div (
                .i_clk (i_clk),
                .i_num (r_num[k]),
                .i_den (r_den),
                .o_quo (w_quo[k]),
                .o_big (w_big[k])
            );

            // sign and saturation: positive limit 2^(DW-1)-1, negative -2^(DW-1)
            always_comb begin
                if (r_sd[DIV_STEPS].singular) begin
                    w_inv[k] = '0;
                    w_ovf[k] = 1'b0;
                end else if (!r_sd[DIV_STEPS].neg[k]) begin
                    if (w_big[k] || w_quo[k][DW-1]) begin
                        w_inv[k] = {1'b0, {(DW-1){1'b1}}};
                        w_ovf[k] = 1'b1;
                    end else begin
                        w_inv[k] = w_quo[k];
                        w_ovf[k] = 1'b0;
                    end
                end else begin
                    if (w_big[k] || (w_quo[k][DW-1] && (|w_quo[k][DW-2:0]))) begin
                        w_inv[k] = {1'b1, {(DW-1){1'b0}}};
                        w_ovf[k] = 1'b1;
                    end else begin
                        w_inv[k] = (~w_quo[k]) + DW'(1);
                        w_ovf[k] = 1'b0;
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        r_den    <= NW'(w_ad) << 1;
        r_p_side <= w_side;
        r_sd[0]  <= r_p_side;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            r_sd[j] <= r_sd[j-1];
        end
    end

    // valid bits alongside the prep stage and the divider lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_sv    <= '0;
            r_done  <= 1'b0;
        end else begin
            r_p_vld <= w_adj_vld;
            r_sv    <= {r_sv[DIV_STEPS-1:0], r_p_vld};
            r_done  <= r_sv[DIV_STEPS];
        end
    end

    always_comb begin
        w_res.inv00    = w_inv[0];
        w_res.inv01    = w_inv[1];
        w_res.inv02    = w_inv[2];
        w_res.inv10    = w_inv[3];
        w_res.inv11    = w_inv[4];
        w_res.inv12    = w_inv[5];
        w_res.inv20    = w_inv[6];
        w_res.inv21    = w_inv[7];
        w_res.inv22    = w_inv[8];
        w_res.singular = r_sd[DIV_STEPS].singular;
        w_res.overflow = |w_ovf;
    end

    // output register, one beat per strobe
    always_ff @(posedge i_clk) begin
        r_res <= w_res;
    end

    assign o_result = r_res;
    assign o_done   = r_done;

endmodule

`default_nettype wire

### hdl/mi3_adj.sv
`default_nettype none

module mi3_adj (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire mi3_pkg::t_matrix i_matrix,
    output logic                  o_valid,
    output mi3_pkg::t_cof         o_cof [mi3_pkg::NE],
    output mi3_pkg::t_det         o_det
);
    import mi3_pkg::*;

    t_entry                  w_a     [NE];
    logic signed [PW-1:0]    r_pp    [NE];
    logic signed [PW-1:0]    r_pq    [NE];
    t_entry                  r_s1_a  [3];
    t_cof                    r_cof   [NE];
    t_entry                  r_s2_a  [3];
    logic signed [2*DW:0]    r_plo   [3];
    logic signed [2*DW:0]    r_phi   [3];
    t_cof                    r_s3_cof[NE];
    t_cof                    r_s4_cof[NE];
    t_det                    w_d;
    t_det                    r_d;
    logic [3:0]              r_vld;

    always_comb begin
        w_a[0] = i_matrix.a00;
        w_a[1] = i_matrix.a01;
        w_a[2] = i_matrix.a02;
        w_a[3] = i_matrix.a10;
        w_a[4] = i_matrix.a11;
        w_a[5] = i_matrix.a12;
        w_a[6] = i_matrix.a20;
        w_a[7] = i_matrix.a21;
        w_a[8] = i_matrix.a22;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    genvar k;
    generate
        for (k = 0; k < NE; k++) begin : g_cof
            // stage 1: 2x2 products, stage 2: differences
            always_ff @(posedge i_clk) begin
                r_pp[k]     <= w_a[COF_IDX[k][0]] * w_a[COF_IDX[k][1]];
                r_pq[k]     <= w_a[COF_IDX[k][2]] * w_a[COF_IDX[k][3]];
                r_cof[k]    <= CW'(r_pp[k]) - CW'(r_pq[k]);
                r_s3_cof[k] <= r_cof[k];
                r_s4_cof[k] <= r_s3_cof[k];
            end
            assign o_cof[k] = r_s4_cof[k];
        end

        for (k = 0; k < 3; k++) begin : g_det
            // stage 3: row-0 entry times cofactor, cofactor split in low and high halves
            always_ff @(posedge i_clk) begin
                r_s1_a[k] <= w_a[k];
                r_s2_a[k] <= r_s1_a[k];
                r_plo[k]  <= r_s2_a[k] * $signed({1'b0, r_cof[3*k][DW-1:0]});
                r_phi[k]  <= r_s2_a[k] * $signed(r_cof[3*k][CW-1:DW]);
            end
        end
    endgenerate

    // stage 4: recombine partial products and sum the expansion
    always_comb begin
        w_d = '0;
        for (int j = 0; j < 3; j++) begin
            w_d = w_d + (DETW'(r_phi[j]) <<< DW) + DETW'(r_plo[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_d <= w_d;
    end

    assign o_det   = r_d;
    assign o_valid = r_vld[3];

endmodule

`default_nettype wire

### hdl/mi3_div.sv
`default_nettype none

module mi3_div #(
    parameter int NW = 200,
    parameter int QW = 32
) (
    input  wire logic          i_clk,
    input  wire logic [NW-1:0] i_num,
    input  wire logic [NW-1:0] i_den,
    output logic      [QW-1:0] o_quo,
    output logic               o_big
);

    logic [NW-1:0] r_rem [QW];
    logic [NW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW+1];
    logic          r_big [QW+1];

    // first stage: flag quotients that do not fit in QW bits
    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
        r_q[0]   <= '0;
        r_big[0] <= i_num >= (i_den << QW);
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_step
            localparam int B = QW - k;
            logic [NW-1:0] w_sh;
            logic          w_ge;

            assign w_sh = r_den[k-1] << B;
            assign w_ge = r_rem[k-1] >= w_sh;

            always_ff @(posedge i_clk) begin
                r_q[k]   <= w_ge ? (r_q[k-1] | (QW'(1) << B)) : r_q[k-1];
                r_big[k] <= r_big[k-1];
            end

            if (k < QW) begin : g_carry
                always_ff @(posedge i_clk) begin
                    r_rem[k] <= w_ge ? (r_rem[k-1] - w_sh) : r_rem[k-1];
                    r_den[k] <= r_den[k-1];
                end
            end
        end
    endgenerate

    assign o_quo = r_q[QW];
    assign o_big = r_big[QW];

endmodule

`default_nettype wire
